@@ hdl/timestamped_quaternion_ring_match_top_assert.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the timestamped quaternion ring match block
// compiled out when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef TIMESTAMPED_QUATERNION_RING_MATCH_TOP_ASSERT_SVH
`define TIMESTAMPED_QUATERNION_RING_MATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TQRM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tqrm assertion failed");

// antecedent implies consequent in the next cycle
`define TQRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tqrm assertion failed");

`else

`define TQRM_ASSERT_SAME(label, clk, rst, ante, cons)

`define TQRM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/tqrm_pkg.sv @@
// ---------------------------------------------------------------------------
// tqrm_pkg
// types and constants shared by the quaternion ring match cells and top
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqrm_pkg;

  localparam int FRAME_SLOTS_DEF = 32;
  localparam int STAMP_W         = 32;
  localparam int SLOT_FIELD_W    = 5;
  localparam int COMP_W          = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_MATCH  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] w;
  } quat_t;

  typedef struct packed {
    op_t                      operation;
    logic [STAMP_W-1:0]       stamp;
    logic signed [COMP_W-1:0] quat_w;
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0]  slot_found;
    logic signed [COMP_W-1:0] found_w;
    logic signed [COMP_W-1:0] found_x;
    logic signed [COMP_W-1:0] found_y;
    logic signed [COMP_W-1:0] found_z;
  } out_item_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic [STAMP_W-1:0]      query;
    logic [STAMP_W-1:0]      diff;
    logic [SLOT_FIELD_W-1:0] slot;
    quat_t                   quat;
  } scan_tok_t;

  // shared write broadcast to every cell
  typedef struct packed {
    logic  en;
    logic [STAMP_W-1:0] stamp;
    quat_t quat;
  } frame_wr_t;

endpackage

@@ hdl/tqrm_cell.sv @@
// ---------------------------------------------------------------------------
// tqrm_cell
// one ring slot: holds a frame and folds it into the passing search token
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqrm_cell #(
  parameter int FRAME_SLOTS = tqrm_pkg::FRAME_SLOTS_DEF,
  parameter int CELL_INDEX  = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tqrm_pkg::frame_wr_t             wr,
  input  logic [$clog2(FRAME_SLOTS)-1:0]  wr_slot,
  input  tqrm_pkg::scan_tok_t             tok_in,
  output tqrm_pkg::scan_tok_t             tok_out
);

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);
  localparam logic [tqrm_pkg::SLOT_FIELD_W-1:0] MY_TAG =
    tqrm_pkg::SLOT_FIELD_W'(CELL_INDEX);
  localparam bit IS_FIRST = (CELL_INDEX == 0);

  logic [tqrm_pkg::STAMP_W-1:0] stamp;
  tqrm_pkg::quat_t              quat;
  logic [tqrm_pkg::STAMP_W-1:0] diff;
  logic                         take;
  tqrm_pkg::scan_tok_t          tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp <= '0;
      quat  <= '0;
    end else if (wr.en && (wr_slot == MY_SLOT)) begin
      stamp <= wr.stamp;
      quat  <= wr.quat;
    end
  end

  always_comb begin
    diff = (stamp >= tok_in.query) ? (stamp - tok_in.query) : (tok_in.query - stamp);
    // strict compare keeps the lower slot on a tie
    take = IS_FIRST || (diff < tok_in.diff);
    tok_next = tok_in;
    if (take) begin
      tok_next.diff = diff;
      tok_next.slot = MY_TAG;
      tok_next.quat = quat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ hdl/timestamped_quaternion_ring_match_top.sv @@
// ---------------------------------------------------------------------------
// timestamped_quaternion_ring_match_top
// ring of timestamped quaternion frames with nearest-timestamp search
// ---------------------------------------------------------------------------
// An insert writes its frame and busy stays low, so another command may
// follow right away. A match sends a search token down the row of
// FRAME_SLOTS cells, one cell per cycle, each cell registering it; the
// result is strobed on done as the token leaves the last cell and busy is
// high until that cycle ends. The result is shown for exactly one cycle and
// must be captured then. After reset all slots hold timestamp zero and a
// zero quaternion.
`timescale 1ns / 1ps
`include "timestamped_quaternion_ring_match_top_assert.svh"

module timestamped_quaternion_ring_match_top #(
  parameter int FRAME_SLOTS = tqrm_pkg::FRAME_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tqrm_pkg::in_item_t  cmd,
  output logic                done,
  output tqrm_pkg::out_item_t result
);

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  logic                accept;
  logic                ins_go;
  logic                match_go;
  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   write_slot_next;
  logic                busy_next;
  tqrm_pkg::frame_wr_t wr;
  tqrm_pkg::scan_tok_t tok [FRAME_SLOTS+1];
  tqrm_pkg::scan_tok_t tail;

  assign accept   = start && !busy;
  assign ins_go   = accept && (cmd.operation == tqrm_pkg::OP_INSERT);
  assign match_go = accept && (cmd.operation == tqrm_pkg::OP_MATCH);

  // pointer advances before the store, wrapping after the last slot
  assign write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (ins_go) begin
      write_slot <= write_slot_next;
    end
  end

  always_comb begin
    wr.en     = ins_go;
    wr.stamp  = cmd.stamp;
    wr.quat.w = cmd.quat_w;
    wr.quat.x = cmd.quat_x;
    wr.quat.y = cmd.quat_y;
    wr.quat.z = cmd.quat_z;
  end

  always_comb begin
    tok[0].valid = match_go;
    tok[0].query = cmd.stamp;
    tok[0].diff  = '0;
    tok[0].slot  = '0;
    tok[0].quat  = '0;
  end

  for (genvar i = 0; i < FRAME_SLOTS; i++) begin : g_cell
    tqrm_cell #(
      .FRAME_SLOTS (FRAME_SLOTS),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .wr_slot (write_slot_next),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail = tok[FRAME_SLOTS];

  always_comb begin
    busy_next = busy;
    if (match_go) begin
      busy_next = 1'b1;
    end else if (tail.valid) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  assign done = tail.valid;

  always_comb begin
    result.slot_found = tail.slot;
    result.found_w    = tail.quat.w;
    result.found_x    = tail.quat.x;
    result.found_y    = tail.quat.y;
    result.found_z    = tail.quat.z;
  end

  `TQRM_ASSERT_SAME(a_done_while_busy, clk, rst, done, busy)
  `TQRM_ASSERT_NEXT(a_match_sets_busy, clk, rst, match_go, busy)
  `TQRM_ASSERT_NEXT(a_done_frees, clk, rst, done, !busy)
  `TQRM_ASSERT_NEXT(a_insert_no_result, clk, rst, ins_go, !done && !busy)

endmodule
